[rtl/trb_pkg.sv]
package trb_pkg;
  localparam int ENTRIES      = 256;
  localparam int RELEASE_KEYS = 100;
  localparam int GROUP_MAX    = 16;
  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int DIST_W = $clog2(RELEASE_KEYS + 1);
  localparam int GRP_W  = $clog2(GROUP_MAX + 1);

  localparam logic CFG_HAS_AUDIO = 1'b0;
  localparam logic CFG_HAS_VIDEO = 1'b1;

  typedef struct packed {
    logic [15:0] tag;
    logic [15:0] length;
    logic [31:0] stamp;
    logic        audio;
  } entry_t;

  typedef struct packed {
    logic        shift_in;   // insert: cell at pos takes the new item, later cells take left neighbor
    logic        shift_out;  // release: every cell takes right neighbor
    logic [31:0] key;        // insert key, compared in every cell
    entry_t      item;
  } cell_ctl_t;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_INSERT, ST_RELEASE} state_t;
endpackage

[rtl/trb_if.sv]
interface trb_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] packet_tag;
  logic [15:0] packet_length;
  logic [31:0] time_stamp;
  logic        audio_flag;
  modport source(output valid, packet_tag, packet_length, time_stamp, audio_flag,
                 input ready);
  modport sink(input valid, packet_tag, packet_length, time_stamp, audio_flag,
               output ready);
endinterface

interface trb_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_tag;
  logic [15:0] out_length;
  logic [31:0] out_stamp;
  logic        out_audio;
  logic        drop_status;
  logic        last_of_group;
  modport source(output valid, out_tag, out_length, out_stamp, out_audio,
                 drop_status, last_of_group, input ready);
  modport sink(input valid, out_tag, out_length, out_stamp, out_audio,
               drop_status, last_of_group, output ready);
endinterface

interface trb_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic        data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

[rtl/trb_cell.sv]
module trb_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  trb_pkg::cell_ctl_t ctl,
  input  logic            left_valid,
  input  trb_pkg::entry_t left_item,
  input  logic            left_gt,
  input  logic            right_valid,
  input  trb_pkg::entry_t right_item,
  output logic            valid_o,
  output trb_pkg::entry_t item_o,
  output logic            gt_o,
  output logic            eq_o
);
  import trb_pkg::*;
  logic   valid_r, valid_nxt;
  entry_t item_r, item_nxt;

  assign gt_o = valid_r && (item_r.stamp > ctl.key);
  assign eq_o = valid_r && (item_r.stamp == ctl.key);

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (ctl.shift_out) begin
      valid_nxt = right_valid;
      item_nxt  = right_item;
    end else if (ctl.shift_in) begin
      // first cell that is greater or empty behind a held entry takes the new item,
      // later ones shift
      if (left_gt) begin
        valid_nxt = left_valid;
        item_nxt  = left_item;
      end else if (left_valid && (gt_o || !valid_r)) begin
        valid_nxt = 1'b1;
        item_nxt  = ctl.item;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
    item_r <= item_nxt;
  end

  assign valid_o = valid_r;
  assign item_o  = item_r;
endmodule

[rtl/timestamp_reorder_buffer.sv]
// Timestamp reorder buffer: a sorted chain of ENTRIES cells.
// In SCAN a nonzero-length item is passed through or dropped into the result register
// or sent on to INSERT; zero-length items are taken and discarded, one per cycle while
// the output is free. An insert that brings the store to RELEASE_KEYS distinct stamps
// releases the head group. Only IDLE takes input; a stalled result holds the block.
// Reset (rst_n low, synchronous): chain empty, counters zero, both mode bits zero.
module timestamp_reorder_buffer (
  input logic clk,
  input logic rst_n,
  trb_in_if.sink    in_ch,
  trb_out_if.source out_ch,
  trb_cfg_if.sink   cfg_ch
);
  import trb_pkg::*;

  state_t state_r, state_nxt;
  logic has_audio_r, has_video_r;
  entry_t in_r;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [DIST_W-1:0] dist_r, dist_nxt;
  logic [GRP_W-1:0]  rel_cnt_r, rel_cnt_nxt;
  logic same_hit_r, same_hit_nxt;

  // result register
  logic   out_valid_r, out_valid_nxt;
  entry_t out_item_r, out_item_nxt;
  logic   out_drop_r, out_drop_nxt, out_last_r, out_last_nxt;

  cell_ctl_t ctl;
  logic   [ENTRIES-1:0] c_valid, c_gt, c_eq;
  entry_t c_item [ENTRIES];

  // configuration only while idle
  assign cfg_ch.ready = (state_r == ST_IDLE);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      has_audio_r <= 1'b0;
      has_video_r <= 1'b0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      if (cfg_ch.index == CFG_HAS_AUDIO) has_audio_r <= cfg_ch.data;
      else                               has_video_r <= cfg_ch.data;
    end
  end

  // chain of cells; head is cell 0. The head sees a held, not greater neighbor,
  // so it takes the new item when it is empty or greater.
  // left_gt: the predecessor is greater, so this cell shifts. The chain is sorted,
  // so every cell behind the first greater one is greater too.
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    logic   lv, lg, rv;
    entry_t li, ri;
    if (g == 0) begin : g_head
      assign lv = 1'b1; assign lg = 1'b0; assign li = '0;
    end else begin : g_mid
      assign lv = c_valid[g-1]; assign lg = c_gt[g-1];
      assign li = c_item[g-1];
    end
    if (g == ENTRIES-1) begin : g_tail
      assign rv = 1'b0; assign ri = '0;
    end else begin : g_body
      assign rv = c_valid[g+1]; assign ri = c_item[g+1];
    end
    trb_cell u_cell (
      .clk, .rst_n, .ctl,
      .left_valid(lv), .left_item(li), .left_gt(lg),
      .right_valid(rv), .right_item(ri),
      .valid_o(c_valid[g]), .item_o(c_item[g]), .gt_o(c_gt[g]), .eq_o(c_eq[g])
    );
  end

  // Equal stamps sit next to each other and a group never exceeds GROUP_MAX, so the
  // group is full exactly when two equal cells lie GROUP_MAX-1 apart.
  wire any_eq   = |c_eq;
  wire grp_full = |(c_eq & (c_eq >> (GROUP_MAX - 1)));

  wire reorder = has_audio_r && has_video_r;
  wire out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE) && out_free;
  wire in_acc = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (in_acc) in_r <= '{tag: in_ch.packet_tag, length: in_ch.packet_length,
                          stamp: in_ch.time_stamp, audio: in_ch.audio_flag};
  end

  always_comb begin
    state_nxt = state_r; fill_nxt = fill_r; dist_nxt = dist_r;
    rel_cnt_nxt = rel_cnt_r; same_hit_nxt = same_hit_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_item_nxt = out_item_r; out_drop_nxt = out_drop_r; out_last_nxt = out_last_r;
    ctl = '{shift_in: 1'b0, shift_out: 1'b0, key: in_r.stamp, item: in_r};
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_ch.packet_length != '0) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (!reorder || grp_full || fill_r == CNT_W'(ENTRIES)) begin
          if (out_free) begin
            out_valid_nxt = 1'b1; out_item_nxt = in_r;
            out_drop_nxt = reorder; out_last_nxt = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else begin
          same_hit_nxt = any_eq;
          state_nxt = ST_INSERT;
        end
      end
      ST_INSERT: begin
        ctl.shift_in = 1'b1;
        fill_nxt = fill_r + 1'b1;
        if (!same_hit_r) dist_nxt = dist_r + 1'b1;
        if (!same_hit_r && dist_r + 1'b1 >= DIST_W'(RELEASE_KEYS)) begin
          state_nxt = ST_RELEASE;
          rel_cnt_nxt = '0;
        end else state_nxt = ST_IDLE;
      end
      ST_RELEASE: begin
        if (out_free) begin
          ctl.shift_out = 1'b1;
          fill_nxt = fill_r - 1'b1;
          rel_cnt_nxt = rel_cnt_r + 1'b1;
          out_valid_nxt = 1'b1; out_item_nxt = c_item[0]; out_drop_nxt = 1'b0;
          out_last_nxt = !c_valid[1] || c_item[1].stamp != c_item[0].stamp ||
                         rel_cnt_r + 1'b1 == GRP_W'(GROUP_MAX);
          if (out_last_nxt) begin
            dist_nxt = dist_r - 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; fill_r <= '0; dist_r <= '0; out_valid_r <= 1'b0;
      rel_cnt_r <= '0; same_hit_r <= 1'b0;
    end else begin
      state_r <= state_nxt; fill_r <= fill_nxt; dist_r <= dist_nxt;
      out_valid_r <= out_valid_nxt; rel_cnt_r <= rel_cnt_nxt;
      same_hit_r <= same_hit_nxt;
    end
    out_item_r <= out_item_nxt; out_drop_r <= out_drop_nxt; out_last_r <= out_last_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.out_tag       = out_item_r.tag;
  assign out_ch.out_length    = out_item_r.length;
  assign out_ch.out_stamp     = out_item_r.stamp;
  assign out_ch.out_audio     = out_item_r.audio;
  assign out_ch.drop_status   = out_drop_r;
  assign out_ch.last_of_group = out_last_r;

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(ENTRIES)) else $error("fill count overflow");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r) else $error("result lost");
  a_rel_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RELEASE |-> rel_cnt_r < GRP_W'(GROUP_MAX)) else $error("group too long");
endmodule

[tb/trb_reorder_model.sv]
package trb_reorder_model;
  import trb_pkg::*;

  typedef struct packed {
    logic [15:0] tag;
    logic [15:0] length;
    logic [31:0] stamp;
    logic        audio;
    logic        dropped;
    logic        last;
  } release_t;

  class jitter_scoreboard;
    entry_t   sorted_q[$];
    int       distinct_stamps;
    bit       audio_on, video_on;
    release_t pending_q[$];
    int       errors;

    function void reset();
      sorted_q.delete();
      pending_q.delete();
      distinct_stamps = 0;
      audio_on = 0;
      video_on = 0;
      errors = 0;
    endfunction

    function void write_mode(logic idx, logic val);
      if (idx == CFG_HAS_AUDIO) audio_on = val;
      else video_on = val;
    endfunction

    function void push(entry_t e, bit drop, bit last);
      release_t r;
      r.tag = e.tag; r.length = e.length; r.stamp = e.stamp; r.audio = e.audio;
      r.dropped = drop; r.last = last;
      pending_q.push_back(r);
    endfunction

    // Predict the results caused by one accepted descriptor.
    function void note_packet(entry_t e);
      int pos, same, n;
      logic [31:0] head;
      if (e.length == 0) return;
      if (!(audio_on && video_on)) begin
        push(e, 0, 1);
        return;
      end
      pos = sorted_q.size();
      same = 0;
      foreach (sorted_q[i]) begin
        if (sorted_q[i].stamp == e.stamp) same++;
        if (sorted_q[i].stamp > e.stamp && pos == sorted_q.size()) pos = i;
      end
      if (same >= GROUP_MAX || sorted_q.size() >= ENTRIES) begin
        push(e, 1, 1);
        return;
      end
      sorted_q.insert(pos, e);
      if (same == 0) distinct_stamps++;
      if (distinct_stamps < RELEASE_KEYS) return;
      head = sorted_q[0].stamp;
      n = 0;
      while (n < sorted_q.size() && n < GROUP_MAX && sorted_q[n].stamp == head) n++;
      for (int k = 0; k < n; k++) push(sorted_q.pop_front(), 0, k + 1 == n);
      distinct_stamps--;
    endfunction

    function void check_result(release_t got);
      release_t want;
      if (pending_q.size() == 0) begin
        $error("unexpected result tag=%0h", got.tag);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got.tag != want.tag) begin
        $error("out_tag exp %0h got %0h", want.tag, got.tag); errors++;
      end
      if (got.length != want.length) begin
        $error("out_length exp %0h got %0h", want.length, got.length); errors++;
      end
      if (got.stamp != want.stamp) begin
        $error("out_stamp exp %0h got %0h", want.stamp, got.stamp); errors++;
      end
      if (got.audio != want.audio) begin
        $error("out_audio exp %0b got %0b", want.audio, got.audio); errors++;
      end
      if (got.dropped != want.dropped) begin
        $error("drop_status exp %0b got %0b", want.dropped, got.dropped); errors++;
      end
      if (got.last != want.last) begin
        $error("last_of_group exp %0b got %0b", want.last, got.last); errors++;
      end
    endfunction
  endclass
endpackage

[tb/tb_timestamp_reorder_buffer.sv]
module tb_timestamp_reorder_buffer;
  timeunit 1ns;
  timeprecision 1ps;
  import trb_pkg::*;
  import trb_reorder_model::*;

  localparam int CYCLE_LIMIT = 600000;

  logic clk = 0;
  logic rst_n = 0;
  trb_in_if  in_ch();
  trb_out_if out_ch();
  trb_cfg_if cfg_ch();

  timestamp_reorder_buffer dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  jitter_scoreboard sb = new();
  int send_idle_pct = 0;     // chance per cycle that the sender holds off
  int recv_stall_pct = 0;    // chance per cycle that the receiver stalls
  bit long_hold = 0;         // receiver holds off while this is set
  int cycles = 0;
  logic [31:0] stamp_base;

  initial begin
    in_ch.valid = 0;
    in_ch.packet_tag = 0;
    in_ch.packet_length = 0;
    in_ch.time_stamp = 0;
    in_ch.audio_flag = 0;
    out_ch.ready = 0;
    cfg_ch.valid = 0;
    cfg_ch.index = CFG_HAS_AUDIO;
    cfg_ch.data = 0;
  end

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: stall at random, or hold off entirely during the long hold.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 0;
    end else begin
      out_ch.ready <= !long_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check each result transaction against the oldest prediction.
  always @(posedge clk) begin
    release_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.tag = out_ch.out_tag;
      got.length = out_ch.out_length;
      got.stamp = out_ch.out_stamp;
      got.audio = out_ch.out_audio;
      got.dropped = out_ch.drop_status;
      got.last = out_ch.last_of_group;
      sb.check_result(got);
    end
  end

  // Write one mode bit; the block accepts it once idle.
  task automatic write_mode(logic idx, logic val);
    cfg_ch.valid <= 1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_mode(idx, val);
    cfg_ch.valid <= 0;
    @(posedge clk);
  endtask

  task automatic set_mode(bit aud, bit vid);
    write_mode(CFG_HAS_AUDIO, aud);
    write_mode(CFG_HAS_VIDEO, vid);
  endtask

  // Offer one descriptor, with a random idle gap first, and wait for acceptance.
  task automatic send_packet(logic [15:0] tag, logic [15:0] len, logic [31:0] ts,
                             logic aud);
    entry_t e;
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    e.tag = tag; e.length = len; e.stamp = ts; e.audio = aud;
    in_ch.valid <= 1;
    in_ch.packet_tag <= tag;
    in_ch.packet_length <= len;
    in_ch.time_stamp <= ts;
    in_ch.audio_flag <= aud;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_packet(e);
    in_ch.valid <= 0;
    @(posedge clk);
  endtask

  // Hold until every prediction is consumed, then let the block settle.
  task automatic drain();
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic send_random(int count, int stamp_span);
    logic [15:0] len;
    repeat (count) begin
      len = $urandom_range(99) < 5 ? 16'd0 : 16'($urandom_range(65535, 1));
      send_packet(16'($urandom), len, stamp_base + $urandom_range(stamp_span),
                  1'($urandom_range(1)));
      stamp_base += $urandom_range(3);
    end
  endtask

  initial begin
    sb.reset();
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: pass-through at field extremes, and a zero-length item.
    set_mode(0, 0);
    send_packet(16'h0000, 16'h0001, 32'h0, 0);
    send_packet(16'hffff, 16'hffff, 32'hffff_ffff, 1);
    send_packet(16'h1234, 16'h0000, 32'h5, 1);
    set_mode(1, 0);
    send_packet(16'haaaa, 16'h5555, 32'h8000_0000, 0);
    set_mode(0, 1);
    send_packet(16'h5555, 16'haaaa, 32'h7fff_ffff, 1);
    drain();

    // Reorder: fill one group past GROUP_MAX to provoke drops.
    set_mode(1, 1);
    for (int i = 0; i < GROUP_MAX + 2; i++)
      send_packet(16'(i), 16'(i + 1), 32'hffff_ffff, i[0]);
    // Mode change with entries held: pass-through leaves them alone.
    drain();
    set_mode(0, 1);
    send_packet(16'hbeef, 16'h10, 32'h0, 0);
    drain();
    set_mode(1, 1);

    // Random reordering with a narrow stamp window so groups form and release.
    stamp_base = 32'hffff_ff00;
    send_idle_pct = 0; recv_stall_pct = 0;
    send_random(100, 40);
    send_idle_pct = 58;
    send_random(60, 40);
    send_idle_pct = 0; recv_stall_pct = 58;
    send_random(60, 40);
    send_idle_pct = 19; recv_stall_pct = 19;
    send_random(60, 30);

    // Long receiver hold while the sender keeps offering items.
    send_idle_pct = 0; recv_stall_pct = 0;
    fork
      begin
        long_hold = 1;
        repeat (400) @(posedge clk);
        long_hold = 0;
      end
      send_random(60, 20);
    join
    drain();

    // Pass-through phase with stored entries still held.
    set_mode(0, 0);
    send_random(40, 1000);
    drain();
    set_mode(1, 1);
    send_random(40, 20);
    drain();

    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
